// ----- src/bsfb_pkg.sv -----
// ----------------------------------------------------------------------------
// bsfb_pkg
// Shared types and constants of the byte-stuffing frame builder.
// ----------------------------------------------------------------------------
package bsfb_pkg;

    localparam int FRAME_BYTES = 1024;
    localparam int FILL_W      = 10;
    localparam int SEQ_W       = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 10;

    localparam logic [FILL_W-1:0] FILL_CAP   = FILL_W'(FRAME_BYTES - 1);
    localparam logic [FILL_W-1:0] FILL_OPEN  = FILL_W'(2);
    localparam logic [FILL_W-1:0] LIMIT_RST  = FILL_W'(1023);
    localparam logic [SEQ_W-1:0]  RESTART_RST = 8'd17;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_DELTA = 8'h10;
    localparam logic [7:0] SEQ_RESET = 8'h30;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTART_SEQ = 1'b1;

    // Output steps of one item, emitted in ascending order.
    localparam int NUM_STEPS = 8;
    localparam int STEP_W    = $clog2(NUM_STEPS);
    localparam logic [STEP_W-1:0] STEP_OPEN_FLAG  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_OPEN_SEQ   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_ESC        = 3'd2;
    localparam logic [STEP_W-1:0] STEP_BODY       = 3'd3;
    localparam logic [STEP_W-1:0] STEP_LEN_CLOSE  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_EMPTY_FLAG = 3'd5;
    localparam logic [STEP_W-1:0] STEP_EMPTY_SEQ  = 3'd6;
    localparam logic [STEP_W-1:0] STEP_END_CLOSE  = 3'd7;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       image_end;
    } bsfb_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_close;
        logic       run_last;
    } bsfb_result_t;

    // Classified item: which steps apply and the bytes that are not constant.
    typedef struct packed {
        logic [NUM_STEPS-1:0] mask;
        logic [SEQ_W-1:0]     hdr_seq;
        logic [7:0]           body;
        logic [SEQ_W-1:0]     end_seq;
    } bsfb_desc_t;

endpackage

// ----- src/byte_stuffing_frame_builder.sv -----
// ----------------------------------------------------------------------------
// byte_stuffing_frame_builder
// Byte-stuffing framer: opens frames with a flag and sequence byte, escapes
// flag, escape and sequence bytes, and closes frames on length or image end.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  item      in         item_valid / item_stall   bsfb_item_t
//  result    out        result_valid / result_stall  bsfb_result_t
//  cfg       in         cfg_we                    cfg_index, cfg_wdata
//
// The front end takes one item per cycle while the four-entry queue has room.
// The back end emits one byte per cycle while the output is not stalled; an
// item yields one to eight bytes, an escaped byte taking two of them.
// A taken item passes through the queue and the back end's mask and
// descriptor registers before its first byte reaches the output register.
// A stalled output holds its beat; the queue absorbs the front end meanwhile.
// Reset clears the frame state and the queue and loads the register defaults.
// ----------------------------------------------------------------------------
module byte_stuffing_frame_builder
    import bsfb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  bsfb_item_t            item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output bsfb_result_t          result
);

    logic       q_push, q_full, q_pop, q_empty;
    bsfb_desc_t q_in, q_head;

    bsfb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_push     (q_push),
        .q_desc     (q_in),
        .q_full     (q_full)
    );

    bsfb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    bsfb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ----- src/bsfb_front.sv -----
// ----------------------------------------------------------------------------
// bsfb_front
// Accepts payload beats, keeps the frame state and classifies each beat into
// a step mask for the back end.
// ----------------------------------------------------------------------------
module bsfb_front
    import bsfb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  bsfb_item_t            item,
    output logic                  q_push,
    output bsfb_desc_t            q_desc,
    input  logic                  q_full
);

    logic [FILL_W-1:0] limit_reg, limit_next;
    logic [SEQ_W-1:0]  restart_reg, restart_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              open_reg, open_next;

    logic              accept;
    logic [FILL_W-1:0] pos_base;
    logic [FILL_W-1:0] eff_limit;
    logic [FILL_W:0]   pos_sum;
    logic              is_flag, is_esc, is_seq, escaped, len_close;
    logic [SEQ_W-1:0]  seq_inc;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;
    assign q_push     = accept;

    always_comb
    begin
        limit_next   = limit_reg;
        restart_next = restart_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FILL_LIMIT:  limit_next   = cfg_wdata[FILL_W-1:0];
                CFG_RESTART_SEQ: restart_next = cfg_wdata[SEQ_W-1:0];
                default:         limit_next   = limit_reg;
            endcase
        end
    end

    always_comb
    begin
        pos_base  = open_reg ? fill_reg : FILL_OPEN;
        eff_limit = (limit_reg < FILL_CAP) ? limit_reg : FILL_CAP;
        is_flag   = (item.data_byte == FLAG_BYTE);
        is_esc    = (item.data_byte == ESC_BYTE);
        is_seq    = (item.data_byte == seq_reg);
        escaped   = is_flag || is_esc || is_seq;
        pos_sum   = {1'b0, pos_base} + (escaped ? (FILL_W+1)'(2) : (FILL_W+1)'(1));
        len_close = (pos_sum >= {1'b0, eff_limit});
        seq_inc   = seq_reg + 8'd1;

        q_desc         = '0;
        q_desc.hdr_seq = seq_reg;
        q_desc.end_seq = seq_inc;
        if (is_flag)
            q_desc.body = FLAG_BYTE + ESC_DELTA;
        else if (is_esc)
            q_desc.body = ESC_BYTE - ESC_DELTA;
        else if (is_seq)
            q_desc.body = seq_reg + ESC_DELTA;
        else
            q_desc.body = item.data_byte;

        q_desc.mask[STEP_OPEN_FLAG]  = !open_reg;
        q_desc.mask[STEP_OPEN_SEQ]   = !open_reg;
        q_desc.mask[STEP_ESC]        = escaped;
        q_desc.mask[STEP_BODY]       = 1'b1;
        q_desc.mask[STEP_LEN_CLOSE]  = len_close;
        // A frame that has just closed on length gets an empty frame at image end.
        q_desc.mask[STEP_EMPTY_FLAG] = item.image_end && len_close;
        q_desc.mask[STEP_EMPTY_SEQ]  = item.image_end && len_close;
        q_desc.mask[STEP_END_CLOSE]  = item.image_end;

        seq_next  = seq_reg;
        fill_next = fill_reg;
        open_next = open_reg;
        if (accept)
        begin
            if (item.image_end)
            begin
                seq_next  = restart_reg;
                fill_next = '0;
                open_next = 1'b0;
            end
            else if (len_close)
            begin
                seq_next  = seq_inc;
                fill_next = '0;
                open_next = 1'b0;
            end
            else
            begin
                fill_next = pos_sum[FILL_W-1:0];
                open_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LIMIT_RST;
            restart_reg <= RESTART_RST;
            seq_reg     <= SEQ_RESET;
            fill_reg    <= '0;
            open_reg    <= 1'b0;
        end
        else
        begin
            limit_reg   <= limit_next;
            restart_reg <= restart_next;
            seq_reg     <= seq_next;
            fill_reg    <= fill_next;
            open_reg    <= open_next;
        end
    end

endmodule

// ----- src/bsfb_queue.sv -----
// ----------------------------------------------------------------------------
// bsfb_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module bsfb_queue
    import bsfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  bsfb_desc_t push_desc,
    output logic       full,
    input  logic       pop,
    output bsfb_desc_t head,
    output logic       empty
);

    bsfb_desc_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/bsfb_back.sv -----
// ----------------------------------------------------------------------------
// bsfb_back
// Expands each classified item into framed bytes, one beat per cycle while the
// output is not stalled, into a registered output.
// ----------------------------------------------------------------------------
module bsfb_back
    import bsfb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  bsfb_desc_t   q_head,
    input  logic         q_empty,
    output logic         q_pop,
    output logic         result_valid,
    input  logic         result_stall,
    output bsfb_result_t result
);

    logic [NUM_STEPS-1:0] mask_reg, mask_next;
    bsfb_desc_t           desc_reg;
    logic                 out_valid_reg, out_valid_next;
    bsfb_result_t         out_reg;

    logic                 cur_valid, advance, load;
    logic [NUM_STEPS-1:0] low_bit, rest;
    logic [STEP_W-1:0]    step;
    bsfb_result_t         beat;

    always_comb
    begin
        step = '0;
        for (int i = NUM_STEPS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                step = STEP_W'(i);
        end
        low_bit   = mask_reg & (~mask_reg + 1'b1);
        rest      = mask_reg & ~low_bit;
        cur_valid = |mask_reg;
        advance   = cur_valid && (!out_valid_reg || !result_stall);
        // The next item is taken as the last beat of this one leaves.
        load      = !q_empty && (!cur_valid || (advance && (rest == '0)));

        beat.frame_close = 1'b0;
        beat.run_last    = (rest == '0);
        case (step)
            STEP_OPEN_FLAG:  beat.out_byte = FLAG_BYTE;
            STEP_OPEN_SEQ:   beat.out_byte = desc_reg.hdr_seq;
            STEP_ESC:        beat.out_byte = ESC_BYTE;
            STEP_BODY:       beat.out_byte = desc_reg.body;
            STEP_LEN_CLOSE:
            begin
                beat.out_byte    = FLAG_BYTE;
                beat.frame_close = 1'b1;
            end
            STEP_EMPTY_FLAG: beat.out_byte = FLAG_BYTE;
            STEP_EMPTY_SEQ:  beat.out_byte = desc_reg.end_seq;
            STEP_END_CLOSE:
            begin
                beat.out_byte    = FLAG_BYTE;
                beat.frame_close = 1'b1;
            end
            default:         beat.out_byte = FLAG_BYTE;
        endcase

        if (load)
            mask_next = q_head.mask;
        else if (advance)
            mask_next = rest;
        else
            mask_next = mask_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign q_pop        = load;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            desc_reg <= q_head;
        if (advance)
            out_reg <= beat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- src/bsfb_checker.sv -----
// ----------------------------------------------------------------------------
// bsfb_checker
// Port-level checks of the frame builder, bound to the top level.
// ----------------------------------------------------------------------------
module bsfb_checker
    import bsfb_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         result_valid,
    input logic         result_stall,
    input bsfb_result_t result
);

    // A beat held back by the sink stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result beat changed");

    // Only a flag byte may carry the closing mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_close |-> result.out_byte == FLAG_BYTE)
        else $error("frame close on a byte other than the flag");

    // The first beat after a flag-and-close must not be a close as well,
    // since every frame carries at least a sequence byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && result.frame_close ##1 result_valid
        |-> !result.frame_close)
        else $error("two closing flags in a row");

endmodule

bind byte_stuffing_frame_builder bsfb_checker u_bsfb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
